// ----- rtl/elta_pkg.sv -----
// ----------------------------------------------------------------------------
// elta_pkg: shared types and constants for the endpoint learning table
// Holds the token that walks the cell chain, the write broadcast that commits
// a beacon, and the result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package elta_pkg;

  // Index and count widths cover the largest supported table (256 entries).
  localparam int unsigned IDX_W = 8;
  localparam int unsigned CNT_W = 9;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned RCNT_W  = 5;
  localparam int unsigned USE_W   = 5;

  localparam logic CMD_BEACON = 1'b0;
  localparam logic CMD_EXPIRE = 1'b1;

  localparam logic [STAT_W-1:0] ST_REFRESHED = 2'd0;
  localparam logic [STAT_W-1:0] ST_ADDED     = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_SWEPT     = 2'd3;

  localparam logic [TIME_W-1:0] MAX_AGE_RST = 32'd300;

  // Token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic              active;
    logic              cmd;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] now;
    logic              sweep_en;
    logic [TIME_W-1:0] threshold;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
    logic [CNT_W-1:0]  removed;
    logic [CNT_W-1:0]  in_use;
  } token_t;

  // Commit of a beacon, broadcast to every cell at the end of a walk.
  typedef struct packed {
    logic              en;
    logic              set_valid;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] stamp;
  } wr_t;

endpackage

`default_nettype wire

// ----- rtl/elta_cell.sv -----
// ----------------------------------------------------------------------------
// elta_cell: one table entry of the learning chain
// Holds one endpoint, updates the passing token and forwards it through a
// register. Expired entries are dropped as the sweep token passes.
// ----------------------------------------------------------------------------
`default_nettype none

module elta_cell #(
  parameter logic [elta_pkg::IDX_W-1:0] CELL_IDX = '0
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire elta_pkg::token_t tok_i,
  input  wire elta_pkg::wr_t    wr_i,
  output elta_pkg::token_t      tok_o
);
  import elta_pkg::*;

  logic              valid_q, valid_d;
  logic [ADDR_W-1:0] addr_q;
  logic [PORT_W-1:0] port_q;
  logic [TIME_W-1:0] stamp_q;
  token_t            tok_d, tok_q;
  logic              match, expire, wr_sel;

  assign wr_sel = wr_i.en && (wr_i.idx == CELL_IDX);
  assign match  = valid_q && (addr_q == tok_i.addr) && (port_q == tok_i.port);
  assign expire = valid_q && tok_i.sweep_en && (stamp_q < tok_i.threshold);

  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    if (tok_i.active) begin
      if (tok_i.cmd == CMD_BEACON) begin
        if (match && !tok_i.hit) begin
          tok_d.hit     = 1'b1;
          tok_d.hit_idx = CELL_IDX;
        end
        if (!valid_q && !tok_i.free_found) begin
          tok_d.free_found = 1'b1;
          tok_d.free_idx   = CELL_IDX;
        end
        tok_d.in_use = tok_i.in_use + CNT_W'(valid_q);
      end else begin
        if (expire) begin
          valid_d       = 1'b0;
          tok_d.removed = tok_i.removed + CNT_W'(1);
        end
        tok_d.in_use = tok_i.in_use + CNT_W'(valid_q && !expire);
      end
    end
    if (wr_sel && wr_i.set_valid) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  // Entry payload is only read while valid, so it needs no reset.
  always_ff @(posedge clk_i) begin
    if (wr_sel) begin
      stamp_q <= wr_i.stamp;
      if (wr_i.set_valid) begin
        addr_q <= wr_i.addr;
        port_q <= wr_i.port;
      end
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

// ----- rtl/endpoint_learning_table_aging_top.sv -----
// ----------------------------------------------------------------------------
// Endpoint learning table with aging: top level
// Learns (address, port) pairs from beacon beats and ages them out on
// expire beats, using a chain of entry cells walked by a request token.
// ----------------------------------------------------------------------------
// Flow: the first cell registers the token of an accepted input beat, each
//   further cell registers it in turn, and the output register then holds the
//   result beat. One item is in flight at a time: the input reopens only after
//   the result beat has been handed over.
// Reset: rst_ni clears all valid bits (empty table), the control state and
//   max_age to 300. Entry payloads are not reset.
`default_nettype none

module endpoint_learning_table_aging_top #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration: max_age
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: src_addr[31:0], src_port[47:32], now[79:48]
  input  wire logic [79:0] s_axis_tdata,
  // tuser: cmd[0]
  input  wire logic [0:0]  s_axis_tuser,
  // Output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: slot[3:0], removed_count[8:4], entries_in_use[13:9], zero[15:14]
  output logic [15:0]      m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]       m_axis_tuser
);
  import elta_pkg::*;

  // Configuration register.
  logic [TIME_W-1:0] max_age_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q <= MAX_AGE_RST;
    end else if (cfg_we_i) begin
      max_age_q <= cfg_wdata_i;
    end
  end

  // Handshake control. One item is in flight at a time; the output register
  // is empty whenever a new beat is taken, so the result always has a home.
  logic busy_q, busy_d;
  logic out_valid_q, out_valid_d;
  logic in_fire, done;

  assign s_axis_tready = !busy_q && !out_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Token chain: tok[0] is injected at accept, tok[TABLE_ENTRIES] emerges.
  token_t tok [TABLE_ENTRIES+1];
  token_t tok_in;
  wr_t    wr;
  logic [TIME_W-1:0] in_now;

  assign in_now = s_axis_tdata[79:48];

  always_comb begin
    tok_in            = '0;
    tok_in.active     = in_fire;
    tok_in.cmd        = s_axis_tuser[0];
    tok_in.addr       = s_axis_tdata[31:0];
    tok_in.port       = s_axis_tdata[47:32];
    tok_in.now        = in_now;
    // Nothing expires before now reaches max_age; the threshold never wraps.
    tok_in.sweep_en   = (in_now >= max_age_q);
    tok_in.threshold  = in_now - max_age_q;
  end

  assign tok[0] = tok_in;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    elta_cell #(
      .CELL_IDX(IDX_W'(i))
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (tok[i]),
      .wr_i  (wr),
      .tok_o (tok[i+1])
    );
  end

  // End of walk: decide the outcome and commit a beacon to its slot.
  token_t            last;
  logic [STAT_W-1:0] res_status;
  logic [IDX_W-1:0]  res_slot;
  logic [CNT_W-1:0]  res_removed;
  logic [CNT_W-1:0]  res_in_use;

  assign last = tok[TABLE_ENTRIES];
  assign done = last.active;

  always_comb begin
    wr           = '0;
    wr.addr      = last.addr;
    wr.port      = last.port;
    wr.stamp     = last.now;
    res_slot     = '0;
    res_removed  = '0;
    res_in_use   = last.in_use;
    res_status   = ST_SWEPT;
    if (last.cmd == CMD_BEACON) begin
      if (last.hit) begin
        res_status = ST_REFRESHED;
        res_slot   = last.hit_idx;
        wr.en      = done;
        wr.idx     = last.hit_idx;
      end else if (last.free_found) begin
        res_status   = ST_ADDED;
        res_slot     = last.free_idx;
        res_in_use   = last.in_use + CNT_W'(1);
        wr.en        = done;
        wr.set_valid = 1'b1;
        wr.idx       = last.free_idx;
      end else begin
        res_status = ST_FULL;
      end
    end else begin
      res_removed = last.removed;
    end
  end

  // Output register.
  logic [STAT_W-1:0] status_q;
  logic [SLOT_W-1:0] slot_q;
  logic [RCNT_W-1:0] removed_q;
  logic [USE_W-1:0]  in_use_q;

  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (in_fire) begin
      busy_d = 1'b1;
    end
    if (done) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      status_q  <= res_status;
      slot_q    <= res_slot[SLOT_W-1:0];
      removed_q <= res_removed[RCNT_W-1:0];
      in_use_q  <= res_in_use[USE_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {2'b00, in_use_q, removed_q, slot_q};

endmodule

`default_nettype wire

// ----- tb/tb_endpoint_learning_table_aging_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_endpoint_learning_table_aging_top: self-checking bench for the table
// Drives beacon and expire beats into the learning table, keeps a shadow copy
// of the table and max_age, and compares every result beat field by field.
// ----------------------------------------------------------------------------

module tb_endpoint_learning_table_aging_top;
  import elta_pkg::*;

  localparam int ENTRIES     = 16;
  localparam int CLK_HALF    = 5;
  localparam int CYCLE_LIMIT = 800000;
  localparam int HOLD_CYCLES = 400;
  // Cycles the chain may still be busy after the last result beat.
  localparam int SETTLE      = ENTRIES + 4;
  localparam int POOL        = 24;

  // One result beat as the table reports it.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [RCNT_W-1:0] removed;
    logic [USE_W-1:0]  in_use;
  } result_t;

  // Shadow of the endpoint table. It applies each accepted beat to its own
  // copy of the entries and queues the result beat the block should return.
  class endpoint_table_shadow;
    logic [TIME_W-1:0] age_limit;
    bit                live[ENTRIES];
    logic [ADDR_W-1:0] addr_tab[ENTRIES];
    logic [PORT_W-1:0] port_tab[ENTRIES];
    logic [TIME_W-1:0] stamp_tab[ENTRIES];
    result_t           pending_results[$];
    int errors, n_items, n_checked, n_added, n_refreshed, n_dropped, n_sweeps, n_removed;

    function new();
      age_limit = MAX_AGE_RST;
      foreach (live[i]) live[i] = 1'b0;
      errors = 0; n_items = 0; n_checked = 0; n_added = 0; n_refreshed = 0;
      n_dropped = 0; n_sweeps = 0; n_removed = 0;
    endfunction

    function void set_age(logic [TIME_W-1:0] age);
      age_limit = age;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void learn_item(logic cmd, logic [ADDR_W-1:0] addr, logic [PORT_W-1:0] port,
                             logic [TIME_W-1:0] now);
      result_t           r;
      int                hit, free_idx, removed, used;
      logic [TIME_W-1:0] thr;
      r = '0;
      hit = -1;
      free_idx = -1;
      removed = 0;
      used = 0;
      n_items++;
      if (cmd == CMD_BEACON) begin
        // Only live entries take part in the lookup.
        for (int i = 0; i < ENTRIES; i++) begin
          if (live[i]) begin
            if (hit < 0 && addr_tab[i] == addr && port_tab[i] == port) hit = i;
          end else if (free_idx < 0) begin
            free_idx = i;
          end
        end
        if (hit >= 0) begin
          stamp_tab[hit] = now;
          r.status = ST_REFRESHED;
          r.slot = hit[SLOT_W-1:0];
          n_refreshed++;
        end else if (free_idx >= 0) begin
          live[free_idx] = 1'b1;
          addr_tab[free_idx] = addr;
          port_tab[free_idx] = port;
          stamp_tab[free_idx] = now;
          r.status = ST_ADDED;
          r.slot = free_idx[SLOT_W-1:0];
          n_added++;
        end else begin
          r.status = ST_FULL;
          n_dropped++;
        end
      end else begin
        // The threshold never wraps: before max_age has passed nothing ages out.
        if (now >= age_limit) begin
          thr = now - age_limit;
          for (int i = 0; i < ENTRIES; i++) begin
            if (live[i] && stamp_tab[i] < thr) begin
              live[i] = 1'b0;
              removed++;
            end
          end
        end
        r.status = ST_SWEPT;
        r.removed = removed[RCNT_W-1:0];
        n_sweeps++;
        n_removed += removed;
      end
      for (int i = 0; i < ENTRIES; i++) if (live[i]) used++;
      r.in_use = used[USE_W-1:0];
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      if (errors < 40) $display("[%0t] ERROR beat %0d: %s", $time, n_checked, msg);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result beat with nothing expected (status %0d)", got.status));
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.slot !== want.slot)
        report($sformatf("slot %0d, expected %0d", got.slot, want.slot));
      if (got.removed !== want.removed)
        report($sformatf("removed_count %0d, expected %0d", got.removed, want.removed));
      if (got.in_use !== want.in_use)
        report($sformatf("entries_in_use %0d, expected %0d", got.in_use, want.in_use));
      n_checked++;
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  endpoint_table_shadow shadow;
  int  cycles;
  bit  src_idle_en;
  bit  sink_idle_en;
  int  hold_cycles_req;

  endpoint_learning_table_aging_top #(
    .TABLE_ENTRIES(ENTRIES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #CLK_HALF;
    clk_i = 1'b0;
    #CLK_HALF;
  end

  // Watchdog: a hung handshake or a lost result beat ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[%0t] ERROR: cycle limit reached, %0d results still outstanding",
               $time, shadow.pending());
      $display("endpoint_learning_table_aging_top: mismatch");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 15);
    else return $urandom_range(30, 80);
  endfunction

  // Result side. Outputs are sampled at the rising edge; a beat counts when
  // tvalid and tready were both high just before that edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      shadow.check_result(result_t'{status:  m_axis_tuser,
                                    slot:    m_axis_tdata[3:0],
                                    removed: m_axis_tdata[8:4],
                                    in_use:  m_axis_tdata[13:9]});
  end

  // The sink changes tready at the falling edge. A long hold-off requested by
  // the stimulus is counted down here, independent of the sender, so that the
  // chain backs up and stalls the input while the sender keeps offering beats.
  initial begin : sink
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles_req > 0) begin
        stall_left = hold_cycles_req;
        hold_cycles_req = 0;
      end
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        if (sink_idle_en && $urandom_range(0, 99) < 30) stall_left = idle_len();
      end
    end
  end

  // Offers one beat from a falling edge and holds it until accepted. tvalid
  // stays high into the next beat unless a gap is drawn.
  task automatic send_item(input logic cmd, input logic [ADDR_W-1:0] addr,
                           input logic [PORT_W-1:0] port, input logic [TIME_W-1:0] now);
    int gap;
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = {now, port, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    shadow.learn_item(cmd, addr, port, now);
    @(negedge clk_i);
    gap = (src_idle_en && $urandom_range(0, 99) < 35) ? idle_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Stops offering and waits until every expected result beat has arrived.
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (shadow.pending() != 0) @(negedge clk_i);
  endtask

  // max_age is only changed with the table idle: all results back and the
  // token walk given time to finish.
  task automatic write_max_age(input logic [TIME_W-1:0] age);
    drain_results();
    repeat (SETTLE) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = age;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    shadow.set_age(age);
  endtask

  // One random phase. Most beats are beacons from a small pool of endpoints,
  // more than the table holds, so entries get refreshed, the table fills and
  // beacons get dropped. Sweeps follow a slowly advancing clock so that entries
  // age out in steady numbers. The rest is noise with arbitrary times.
  task automatic run_phase(input int n_items, input logic [TIME_W-1:0] age,
                           input bit src_idle, input bit sink_idle,
                           input bit hold_off, input bit pause_mid);
    logic [ADDR_W-1:0] pool_addr[POOL];
    logic [PORT_W-1:0] pool_port[POOL];
    logic [TIME_W-1:0] t;
    int                step_max, k, r;
    write_max_age(age);
    src_idle_en  = src_idle;
    sink_idle_en = sink_idle;
    // Some pool members share an address or a port with their neighbor, so
    // the lookup has to match on both.
    for (int i = 0; i < POOL; i++) begin
      pool_addr[i] = (i % 4 == 1) ? pool_addr[i-1] : $urandom;
      pool_port[i] = (i % 4 == 3) ? pool_port[i-1] : PORT_W'($urandom_range(0, 65535));
    end
    case ($urandom_range(0, 3))
      0: t = '0;
      1: t = $urandom;
      2: t = 32'hFFFF_F000;
      default: t = $urandom_range(0, 1000);
    endcase
    if (age == 0) step_max = 3;
    else if (age > 400) step_max = 40;
    else step_max = age / 4 + 1;
    if (hold_off) hold_cycles_req = HOLD_CYCLES;
    for (int n = 0; n < n_items; n++) begin
      if (pause_mid && n == n_items / 2) drain_results();
      r = $urandom_range(0, 99);
      k = $urandom_range(0, POOL - 1);
      t = t + $urandom_range(0, step_max);
      if (r < 72) send_item(CMD_BEACON, pool_addr[k], pool_port[k], t);
      else if (r < 88)
        send_item(CMD_EXPIRE, $urandom, PORT_W'($urandom_range(0, 65535)), t);
      else if (r < 94)
        send_item(CMD_BEACON, $urandom, PORT_W'($urandom_range(0, 65535)), $urandom);
      else
        send_item(CMD_EXPIRE, $urandom, PORT_W'($urandom_range(0, 65535)), $urandom);
    end
  endtask

  initial begin : stimulus
    shadow          = new();
    cycles          = 0;
    hold_cycles_req = 0;
    src_idle_en     = 1'b0;
    sink_idle_en    = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part, run with the reset value of max_age (300).
    // A sweep on the empty table before max_age has passed.
    send_item(CMD_EXPIRE, '0, '0, '0);
    // Field extremes: all-zero and all-one pairs and times.
    send_item(CMD_BEACON, '0, '0, '0);
    send_item(CMD_BEACON, '1, '1, '1);
    // Same pair again refreshes its slot; same address with another port adds.
    send_item(CMD_BEACON, '0, '0, 32'd100);
    send_item(CMD_BEACON, '0, 16'd1, 32'd50);
    // Still before max_age: nothing may go, and the beacon fields are ignored.
    send_item(CMD_EXPIRE, 32'hDEAD_BEEF, 16'hBEEF, 32'd299);
    // Threshold 100: the stamp equal to it stays, the one in the future stays,
    // the stamp at 50 goes.
    send_item(CMD_EXPIRE, '1, '1, 32'd400);
    // Fill every free slot, then one beacon more is dropped.
    for (int i = 0; i < ENTRIES - 2; i++)
      send_item(CMD_BEACON, 32'h0A00_0000 + i, i[PORT_W-1:0], 32'd500 + i);
    send_item(CMD_BEACON, 32'h0B00_0000, 16'h00FF, 32'd600);
    // A sweep at the very top of time clears all but the entry stamped there,
    // and the next beacon lands in the lowest free slot again.
    send_item(CMD_EXPIRE, '0, '0, '1);
    send_item(CMD_BEACON, 32'h1234_5678, 16'h8001, 32'd700);

    // Random phases over several max_age settings, both extremes included.
    run_phase(185, '0,                      1'b0, 1'b0, 1'b0, 1'b0);
    run_phase(185, '1,                      1'b1, 1'b1, 1'b1, 1'b0);
    run_phase(185, $urandom_range(20, 200), 1'b1, 1'b1, 1'b0, 1'b1);
    run_phase(185, 32'd1,                   1'b1, 1'b0, 1'b1, 1'b0);
    run_phase(185, MAX_AGE_RST,             1'b1, 1'b1, 1'b0, 1'b1);

    drain_results();
    repeat (SETTLE) @(negedge clk_i);

    $display("Ran %0d beats: %0d adds, %0d refreshes, %0d beacons dropped on a full table,",
             shadow.n_items, shadow.n_added, shadow.n_refreshed, shadow.n_dropped);
    $display("and %0d sweeps removing %0d entries, over six max_age settings; %0d errors.",
             shadow.n_sweeps, shadow.n_removed, shadow.errors);
    if (shadow.errors == 0) begin
      $display("endpoint_learning_table_aging_top: match");
    end else begin
      $display("endpoint_learning_table_aging_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/elta_pkg.sv
rtl/elta_cell.sv
rtl/endpoint_learning_table_aging_top.sv
tb/tb_endpoint_learning_table_aging_top.sv
